/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define AST_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a implies b in the next cycle
`define AST_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

/* rtl/rsc_pkg.sv */
// package: types, constants and table reset values of the steer collision check
package rsc_pkg;
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned CW = 21;
	localparam int unsigned RW = 20;
	localparam int unsigned PW = 22;
	localparam int unsigned CFG_IW = 3;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	localparam logic [CFG_IW-1:0] REG_MAX_STEP = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ACTOR_RADIUS = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GOAL_X = 3'd2;
	localparam logic [CFG_IW-1:0] REG_GOAL_Y = 3'd3;
	localparam logic [CFG_IW-1:0] REG_OBSTACLE_COUNT = 3'd4;

	typedef struct packed {
		logic                 valid;
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic                 hit;
	} pk_t;

	function automatic logic signed [CW-1:0] init_cx(int unsigned i);
		logic signed [CW-1:0] v;
		case (i)
			0: v = CW'(50 << FRAC_BITS);
			1: v = CW'(50 << FRAC_BITS);
			2: v = CW'(300 << FRAC_BITS);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [CW-1:0] init_cy(int unsigned i);
		logic signed [CW-1:0] v;
		case (i)
			0: v = CW'(50 << FRAC_BITS);
			1: v = CW'(100 << FRAC_BITS);
			2: v = CW'(300 << FRAC_BITS);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [RW-1:0] init_rad(int unsigned i);
		logic [RW-1:0] v;
		case (i)
			0: v = RW'(15 << FRAC_BITS);
			1: v = RW'(10 << FRAC_BITS);
			2: v = RW'(60 << FRAC_BITS);
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

/* rtl/rsc_if.sv */
// channel interfaces: request items in, result items out
interface rsc_req_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [2:0]        entry_index;
	logic signed [20:0] entry_x;
	logic signed [20:0] entry_y;
	logic [19:0]       entry_radius;
	logic signed [20:0] src_x;
	logic signed [20:0] src_y;
	logic signed [20:0] dst_x;
	logic signed [20:0] dst_y;
	modport source(output valid, req_type, entry_index, entry_x, entry_y, entry_radius,
		src_x, src_y, dst_x, dst_y, input ready);
	modport sink(input valid, req_type, entry_index, entry_x, entry_y, entry_radius,
		src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface rsc_rsp_if;
	logic              valid;
	logic              ready;
	logic              is_free;
	logic signed [21:0] new_x;
	logic signed [21:0] new_y;
	logic signed [21:0] step_x;
	logic signed [21:0] step_y;
	logic              at_goal;
	modport source(output valid, is_free, new_x, new_y, step_x, step_y, at_goal,
		input ready);
	modport sink(input valid, is_free, new_x, new_y, step_x, step_y, at_goal,
		output ready);
endinterface

/* rtl/rsc_steer.sv */
// steer unit: step, length clamp with iterative square root and division
module rsc_steer
	import rsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] sx,
	input  logic signed [CW-1:0] sy,
	input  logic signed [CW-1:0] tx,
	input  logic signed [CW-1:0] ty,
	input  logic [RW-1:0]        max_step,
	output logic                 done,
	output logic signed [PW-1:0] new_x,
	output logic signed [PW-1:0] new_y,
	output logic signed [PW-1:0] step_x,
	output logic signed [PW-1:0] step_y
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SQ   = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_SQRT = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} st_t;

	st_t                 state_q;
	logic [4:0]          cnt_q;
	logic                done_q;
	logic signed [CW-1:0] sx_q, sy_q;
	logic signed [PW-1:0] dx_q, dy_q;
	logic [42:0]         sqx_q, sqy_q;
	logic [39:0]         lim_q;
	logic [43:0]         d2_q;
	logic [21:0]         root_q;
	logic [24:0]         rem_q;
	logic [41:0]         numx_q, numy_q;
	logic [21:0]         rx_q, ry_q;
	logic [20:0]         qx_q, qy_q;
	logic signed [PW-1:0] nx_q, ny_q;

	logic signed [43:0] px, py;
	logic [43:0]        d2;
	logic [24:0]        rem_n, trial;
	logic [21:0]        magx, magy;
	logic [41:0]        prodx, prody;
	logic [22:0]        rxn, ryn, len_e;

	assign px = dx_q * dx_q;
	assign py = dy_q * dy_q;
	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign rem_n = {rem_q[22:0], d2_q[43:42]};
	assign trial = {1'b0, root_q, 2'b01};
	assign magx = dx_q[PW-1] ? 22'(-dx_q) : 22'(dx_q);
	assign magy = dy_q[PW-1] ? 22'(-dy_q) : 22'(dy_q);
	assign prodx = magx * max_step;
	assign prody = magy * max_step;
	assign len_e = {1'b0, root_q};
	assign rxn = {rx_q, numx_q[41]};
	assign ryn = {ry_q, numy_q[41]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_SQ;
				ST_SQ: state_q <= ST_CMP;
				ST_CMP: begin
					cnt_q <= 5'd21;
					state_q <= (d2 > {4'd0, lim_q}) ? ST_SQRT : ST_FIN;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= 5'd20;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sx_q <= sx;
					sy_q <= sy;
					dx_q <= PW'(tx) - PW'(sx);
					dy_q <= PW'(ty) - PW'(sy);
				end
			end
			ST_SQ: begin
				sqx_q <= px[42:0];
				sqy_q <= py[42:0];
				lim_q <= max_step * max_step;
			end
			ST_CMP: begin
				d2_q <= d2;
				root_q <= '0;
				rem_q <= '0;
			end
			ST_SQRT: begin
				d2_q <= {d2_q[41:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					root_q <= {root_q[20:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					root_q <= {root_q[20:0], 1'b0};
				end
			end
			ST_MUL: begin
				numx_q <= {prodx[20:0], 21'd0};
				numy_q <= {prody[20:0], 21'd0};
				rx_q <= {1'b0, prodx[41:21]};
				ry_q <= {1'b0, prody[41:21]};
			end
			ST_DIV: begin
				numx_q <= {numx_q[40:0], 1'b0};
				numy_q <= {numy_q[40:0], 1'b0};
				if (rxn >= len_e) begin
					rx_q <= 22'(rxn - len_e);
					qx_q <= {qx_q[19:0], 1'b1};
				end else begin
					rx_q <= rxn[21:0];
					qx_q <= {qx_q[19:0], 1'b0};
				end
				if (ryn >= len_e) begin
					ry_q <= 22'(ryn - len_e);
					qy_q <= {qy_q[19:0], 1'b1};
				end else begin
					ry_q <= ryn[21:0];
					qy_q <= {qy_q[19:0], 1'b0};
				end
				if (cnt_q == '0) begin
					dx_q <= dx_q[PW-1] ? -PW'({qx_q[19:0], rxn >= len_e})
						: PW'({qx_q[19:0], rxn >= len_e});
					dy_q <= dy_q[PW-1] ? -PW'({qy_q[19:0], ryn >= len_e})
						: PW'({qy_q[19:0], ryn >= len_e});
				end
			end
			ST_FIN: begin
				nx_q <= PW'(sx_q) + dx_q;
				ny_q <= PW'(sy_q) + dy_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign new_x = nx_q;
	assign new_y = ny_q;
	assign step_x = dx_q;
	assign step_y = dy_q;
endmodule

/* rtl/rsc_cell.sv */
// chain cell: circle distance test of the passing point against one center
module rsc_cell
	import rsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pk_t                  pk_i,
	input  logic                 en,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	input  logic [RW-1:0]        rad,
	input  logic [RW-1:0]        actor,
	output pk_t                  pk_o
);
	pk_t                pk_s1, pk_s2, pk_s3;
	logic               en_s1, en_s2;
	logic signed [22:0] dxo_s1, dyo_s1;
	logic [20:0]        rs_s1;
	logic [44:0]        sqx_s2, sqy_s2;
	logic [41:0]        rs2_s2;
	logic signed [45:0] px, py;
	logic [45:0]        dist2;

	assign px = dxo_s1 * dxo_s1;
	assign py = dyo_s1 * dyo_s1;
	assign dist2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_s1 <= '0;
			pk_s2 <= '0;
			pk_s3 <= '0;
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
			dxo_s1 <= '0;
			dyo_s1 <= '0;
			rs_s1 <= '0;
			sqx_s2 <= '0;
			sqy_s2 <= '0;
			rs2_s2 <= '0;
		end else begin
			pk_s1 <= pk_i;
			en_s1 <= en;
			dxo_s1 <= 23'(pk_i.x) - 23'(cx);
			dyo_s1 <= 23'(pk_i.y) - 23'(cy);
			rs_s1 <= {1'b0, actor} + {1'b0, rad};
			pk_s2 <= pk_s1;
			en_s2 <= en_s1;
			sqx_s2 <= px[44:0];
			sqy_s2 <= py[44:0];
			rs2_s2 <= rs_s1 * rs_s1;
			pk_s3.valid <= pk_s2.valid;
			pk_s3.x <= pk_s2.x;
			pk_s3.y <= pk_s2.y;
			pk_s3.hit <= pk_s2.hit | (en_s2 & (dist2 < {4'd0, rs2_s2}));
		end
	end

	assign pk_o = pk_s3;
endmodule

/* rtl/rrt_steer_collision_check_top.sv */
// Steer step with circle collision check. A load item (req_type 0) writes one
// obstacle slot and returns nothing. A query item goes through the steer
// unit: states SQ, CMP and FIN when the step is short enough, and SQ, CMP,
// SQRT, MUL, DIV and FIN when it is clamped (22 square-root steps and 21
// division steps, both one bit pair or one bit a cycle). The new point then
// walks a row of MAX_OBSTACLES obstacle cells, each registered through
// pk_s1, pk_s2 and pk_s3, plus one goal cell and one output register.
// One query is in flight at a time; the next item is taken once the result
// has been taken. Configuration is written through cfg_we, cfg_idx,
// cfg_wdata.
`include "assert_macros.svh"

module rrt_steer_collision_check_top
	import rsc_pkg::*;
#(
	parameter int unsigned MAX_OBSTACLES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	rsc_req_if.sink           req,
	rsc_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [CW-1:0]     cfg_wdata
);
	logic [RW-1:0]        max_step_q, actor_q;
	logic signed [CW-1:0] goal_x_q, goal_y_q;
	logic [3:0]           count_q;
	logic                 busy_q, out_valid_q, hit_q, goal_q;
	logic                 acc, st_done;
	logic signed [PW-1:0] new_x, new_y, step_x, step_y;
	pk_t                  chain [MAX_OBSTACLES+1];
	pk_t                  goal_in, goal_out;

	assign acc = req.valid && req.ready;
	assign req.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= '0;
			actor_q <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			count_q <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_STEP: max_step_q <= cfg_wdata[RW-1:0];
				REG_ACTOR_RADIUS: actor_q <= cfg_wdata[RW-1:0];
				REG_GOAL_X: goal_x_q <= cfg_wdata;
				REG_GOAL_Y: goal_y_q <= cfg_wdata;
				REG_OBSTACLE_COUNT: count_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	rsc_steer u_steer (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && req.req_type == REQ_QUERY),
		.sx       (req.src_x),
		.sy       (req.src_y),
		.tx       (req.dst_x),
		.ty       (req.dst_y),
		.max_step (max_step_q),
		.done     (st_done),
		.new_x    (new_x),
		.new_y    (new_y),
		.step_x   (step_x),
		.step_y   (step_y)
	);

	assign chain[0] = '{valid: st_done, x: new_x, y: new_y, hit: 1'b0};

	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		logic signed [CW-1:0] cx_q, cy_q;
		logic [RW-1:0]        rad_q;
		logic                 en;

		assign en = {28'd0, count_q} > 32'(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cx_q <= init_cx(i);
				cy_q <= init_cy(i);
				rad_q <= init_rad(i);
			end else if (acc && req.req_type == REQ_LOAD
				&& {29'd0, req.entry_index} == 32'(i)) begin
				cx_q <= req.entry_x;
				cy_q <= req.entry_y;
				rad_q <= req.entry_radius;
			end
		end

		rsc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.pk_i   (chain[i]),
			.en     (en),
			.cx     (cx_q),
			.cy     (cy_q),
			.rad    (rad_q),
			.actor  (actor_q),
			.pk_o   (chain[i+1])
		);
	end

	// goal test is a cell with zero radius
	assign goal_in = '{valid: chain[MAX_OBSTACLES].valid, x: chain[MAX_OBSTACLES].x,
		y: chain[MAX_OBSTACLES].y, hit: 1'b0};

	rsc_cell u_goal (
		.clk    (clk),
		.arst_n (arst_n),
		.pk_i   (goal_in),
		.en     (1'b1),
		.cx     (goal_x_q),
		.cy     (goal_y_q),
		.rad    ('0),
		.actor  (actor_q),
		.pk_o   (goal_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && req.req_type == REQ_QUERY) busy_q <= 1'b1;
			else if (rsp.valid && rsp.ready) busy_q <= 1'b0;
			if (goal_out.valid) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[MAX_OBSTACLES].valid) hit_q <= chain[MAX_OBSTACLES].hit;
		if (goal_out.valid) goal_q <= goal_out.hit;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.is_free = !hit_q;
	assign rsp.at_goal = goal_q;
	assign rsp.new_x = new_x;
	assign rsp.new_y = new_y;
	assign rsp.step_x = step_x;
	assign rsp.step_y = step_y;

	`AST_IMP(a_out_busy, clk, arst_n, out_valid_q, busy_q)
	`AST_IMP(a_done_busy, clk, arst_n, st_done, busy_q && !out_valid_q)
	`AST_NXT(a_result_shown, clk, arst_n, goal_out.valid, out_valid_q)
endmodule

/* tb/sv/tb.sv */
// testbench for the steer collision check: directed and random items checked against a predictor
module tb;
	import rsc_pkg::*;

	localparam int unsigned NUM_SLOTS = 8;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam longint unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		req_type_t            kind;
		logic [2:0]           slot;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic [RW-1:0]        orad;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
	} request_t;

	typedef struct {
		logic                 is_free;
		logic signed [PW-1:0] new_x;
		logic signed [PW-1:0] new_y;
		logic signed [PW-1:0] step_x;
		logic signed [PW-1:0] step_y;
		logic                 at_goal;
	} steer_t;

	class steer_scoreboard;
		logic signed [CW-1:0] obs_x[NUM_SLOTS];
		logic signed [CW-1:0] obs_y[NUM_SLOTS];
		logic [RW-1:0]        obs_rad[NUM_SLOTS];
		logic [RW-1:0]        max_step;
		logic [RW-1:0]        actor_rad;
		logic signed [CW-1:0] goal_x;
		logic signed [CW-1:0] goal_y;
		logic [3:0]           obs_count;
		steer_t               expected_steps[$];
		int                   errors;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				obs_x[i] = init_cx(i);
				obs_y[i] = init_cy(i);
				obs_rad[i] = init_rad(i);
			end
			max_step = '0;
			actor_rad = '0;
			goal_x = '0;
			goal_y = '0;
			obs_count = 4'd3;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] val);
			case (idx)
				REG_MAX_STEP: max_step = val[RW-1:0];
				REG_ACTOR_RADIUS: actor_rad = val[RW-1:0];
				REG_GOAL_X: goal_x = val;
				REG_GOAL_Y: goal_y = val;
				REG_OBSTACLE_COUNT: obs_count = val[3:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint clamp_comp(longint c, longint len);
			longint m, q;
			m = (c < 0) ? -c : c;
			q = (m * longint'(max_step)) / len;
			return (c < 0) ? -q : q;
		endfunction

		function void note_request(request_t r);
			longint sx, sy, dx, dy, nx, ny, d2, ms, len, rs, ex, ey;
			int n;
			steer_t e;
			if (r.kind == REQ_LOAD) begin
				obs_x[r.slot] = r.ox;
				obs_y[r.slot] = r.oy;
				obs_rad[r.slot] = r.orad;
				return;
			end
			sx = r.sx;
			sy = r.sy;
			dx = longint'(r.tx) - sx;
			dy = longint'(r.ty) - sy;
			d2 = dx * dx + dy * dy;
			ms = longint'(max_step);
			if (d2 > ms * ms) begin
				len = int_sqrt(d2);
				if (len != 0) begin
					dx = clamp_comp(dx, len);
					dy = clamp_comp(dy, len);
				end
			end
			nx = sx + dx;
			ny = sy + dy;
			n = (obs_count > NUM_SLOTS) ? NUM_SLOTS : obs_count;
			e.is_free = 1'b1;
			for (int i = 0; i < n; i++) begin
				rs = longint'(actor_rad) + longint'(obs_rad[i]);
				ex = nx - longint'(obs_x[i]);
				ey = ny - longint'(obs_y[i]);
				if (ex * ex + ey * ey < rs * rs) begin
					e.is_free = 1'b0;
					break;
				end
			end
			ex = nx - longint'(goal_x);
			ey = ny - longint'(goal_y);
			e.at_goal = (ex * ex + ey * ey) < longint'(actor_rad) * longint'(actor_rad);
			e.new_x = nx[PW-1:0];
			e.new_y = ny[PW-1:0];
			e.step_x = dx[PW-1:0];
			e.step_y = dy[PW-1:0];
			expected_steps = {expected_steps, e};
		endfunction

		function void check_result(steer_t a);
			steer_t e;
			if (expected_steps.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
				return;
			end
			e = expected_steps.pop_front();
			if (a.is_free !== e.is_free) begin
				$error("is_free expected %0d got %0d", e.is_free, a.is_free);
				errors++;
			end
			if (a.new_x !== e.new_x) begin
				$error("new_x expected %0d got %0d", e.new_x, a.new_x);
				errors++;
			end
			if (a.new_y !== e.new_y) begin
				$error("new_y expected %0d got %0d", e.new_y, a.new_y);
				errors++;
			end
			if (a.step_x !== e.step_x) begin
				$error("step_x expected %0d got %0d", e.step_x, a.step_x);
				errors++;
			end
			if (a.step_y !== e.step_y) begin
				$error("step_y expected %0d got %0d", e.step_y, a.step_y);
				errors++;
			end
			if (a.at_goal !== e.at_goal) begin
				$error("at_goal expected %0d got %0d", e.at_goal, a.at_goal);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_idx;
	logic [CW-1:0] cfg_wdata;
	longint unsigned cycles;
	int stall_mode;

	rsc_req_if req ();
	rsc_rsp_if rsp ();
	steer_scoreboard sb = new();

	rrt_steer_collision_check_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		steer_t a;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			a.is_free = rsp.is_free;
			a.new_x = rsp.new_x;
			a.new_y = rsp.new_y;
			a.step_x = rsp.step_x;
			a.step_y = rsp.step_y;
			a.at_goal = rsp.at_goal;
			sb.check_result(a);
		end
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 1) == 0);
			2: rsp.ready <= ($urandom_range(0, 7) == 0);
			default: rsp.ready <= (cycles % 23) > 15;
		endcase
	end

	task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic send(request_t r);
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.entry_index <= r.slot;
		req.entry_x <= r.ox;
		req.entry_y <= r.oy;
		req.entry_radius <= r.orad;
		req.src_x <= r.sx;
		req.src_y <= r.sy;
		req.dst_x <= r.tx;
		req.dst_y <= r.ty;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_steps.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic request_t query(longint sx, longint sy, longint tx, longint ty);
		request_t r;
		r.kind = REQ_QUERY;
		r.slot = 3'($urandom);
		r.ox = CW'($urandom);
		r.oy = CW'($urandom);
		r.orad = RW'($urandom);
		r.sx = CW'(sx);
		r.sy = CW'(sy);
		r.tx = CW'(tx);
		r.ty = CW'(ty);
		return r;
	endfunction

	function automatic request_t load(int slot, longint x, longint y, longint rad);
		request_t r;
		r = query($urandom, $urandom, $urandom, $urandom);
		r.kind = REQ_LOAD;
		r.slot = 3'(slot);
		r.ox = CW'(x);
		r.oy = CW'(y);
		r.orad = RW'(rad);
		return r;
	endfunction

	function automatic longint near(longint c, int spread);
		return c + $signed($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic request_t random_item();
		int slot, mode;
		longint sx, sy;
		slot = $urandom_range(0, NUM_SLOTS - 1);
		mode = $urandom_range(0, 9);
		case (mode)
			0: return load(slot, $signed(CW'($urandom)), $signed(CW'($urandom)), $urandom);
			1: return load(slot, near(0, 80000), near(0, 80000), $urandom_range(0, 20000));
			2: return query($signed(CW'($urandom)), $signed(CW'($urandom)),
				$signed(CW'($urandom)), $signed(CW'($urandom)));
			3, 4, 5: begin
				sx = near(sb.obs_x[slot], 20000);
				sy = near(sb.obs_y[slot], 20000);
				return query(sx, sy, near(sx, 8000), near(sy, 8000));
			end
			6: begin
				sx = near(sb.goal_x, 20000);
				sy = near(sb.goal_y, 20000);
				return query(sx, sy, near(sb.goal_x, 2000), near(sb.goal_y, 2000));
			end
			default: begin
				sx = near(0, 100000);
				sy = near(0, 100000);
				return query(sx, sy, near(sx, 30000), near(sy, 30000));
			end
		endcase
	endfunction

	task automatic set_config(longint ms, longint ar, longint gx, longint gy, int cnt);
		cfg_write(REG_MAX_STEP, CW'(ms));
		cfg_write(REG_ACTOR_RADIUS, CW'(ar));
		cfg_write(REG_GOAL_X, CW'(gx));
		cfg_write(REG_GOAL_Y, CW'(gy));
		cfg_write(REG_OBSTACLE_COUNT, CW'(cnt));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int burst, gap;
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		stall_mode = 0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_LOAD;
		req.entry_index = '0;
		req.entry_x = '0;
		req.entry_y = '0;
		req.entry_radius = '0;
		req.src_x = '0;
		req.src_y = '0;
		req.dst_x = '0;
		req.dst_y = '0;
		rsp.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset table, zero max step
		send(query(12800, 12800, 12800, 12800));
		send(query(1000, -2000, 50000, 70000));
		send(query(-1048576, -1048576, 1048575, 1048575));
		wait_idle();
		set_config(2560, 768, 0, 0, 3);
		send(query(12800 + 4608, 12800, 12800 + 4608, 12800));
		send(query(12800 + 4607, 12800, 12800 + 4607, 12800));
		send(query(0, 0, 100, 0));
		send(query(0, 0, 768, 0));
		send(query(0, 0, 3000, -4000));
		send(query(-1048576, 1048575, 1048575, -1048576));
		send(query(76800, 76800, 80000, 76800));
		send(load(0, 1048575, -1048576, 1048575));
		send(load(7, -1048576, 1048575, 0));
		send(load(3, 0, 0, 1000));
		wait_idle();
		set_config(1048575, 1048575, 1048575, -1048576, 8);
		send(query(0, 0, 0, 0));
		send(query(-1048576, -1048576, 1048575, 1048575));
		send(query(1048575, 1048575, -1048576, -1048576));
		send(load(7, 5000, 5000, 100));
		wait_idle();
		set_config(0, 0, -1048576, 1048575, 15);
		send(query(5, 5, 5, 5));
		send(query(5, 5, 9, 5));
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(2560, 768, 0, 0, 3);
				1: set_config(0, 1048575, 1048575, 1048575, 0);
				2: set_config(1048575, 0, -1048576, -1048576, 8);
				3: set_config($urandom_range(0, 1048575), $urandom_range(0, 4000),
					$signed(CW'($urandom)), $signed(CW'($urandom)), 15);
				4: set_config(256, 2000, 12800, 12800, 5);
				default: set_config($urandom_range(1, 30000), $urandom_range(0, 30000),
					near(0, 50000), near(0, 50000), 9);
			endcase
			burst = $urandom_range(1, 20);
			for (int i = 0; i < 225; i++) begin
				send(random_item());
				burst--;
				if (burst == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					if (gap > 0) begin
						req.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst = $urandom_range(1, 20);
				end
			end
			wait_idle();
		end

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
